// ----- hw/rtl/cle_pkg.sv -----
`default_nettype none
package cle_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int DATA_W = 8;
    localparam int CAP_W = 7;
    localparam int REQ_W = 4;
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [DATA_W-1:0] EMPTY_REMOVE_CODE = 8'h30;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    typedef enum logic [REQ_W-1:0] {
        REQ_BEGIN     = 4'd0,
        REQ_END       = 4'd1,
        REQ_NEXT      = 4'd2,
        REQ_PRIOR     = 4'd3,
        REQ_INS_AFTER = 4'd4,
        REQ_INS_BEFORE = 4'd5,
        REQ_REMOVE    = 4'd6,
        REQ_REPLACE   = 4'd7,
        REQ_CLEAR     = 4'd8
    } req_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_OPEN,
        CELL_CLOSE,
        CELL_WRITE
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [IDX_W-1:0]    pos;
        logic [DATA_W-1:0]   data;
    } cell_cmd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/cle_cell.sv -----
`default_nettype none
module cle_cell (
    input  wire logic                         clk,
    input  wire logic [cle_pkg::IDX_W-1:0]    idx,
    input  wire cle_pkg::cell_cmd_t           cmd,
    input  wire logic [cle_pkg::DATA_W-1:0]   low_data,
    input  wire logic [cle_pkg::DATA_W-1:0]   high_data,
    output logic      [cle_pkg::DATA_W-1:0]   data
);
    import cle_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            CELL_OPEN:
            begin
                if (idx == cmd.pos)
                begin
                    data_next = cmd.data;
                end
                else if (idx > cmd.pos)
                begin
                    data_next = low_data;
                end
            end
            CELL_CLOSE:
            begin
                if (idx >= cmd.pos)
                begin
                    data_next = high_data;
                end
            end
            CELL_WRITE:
            begin
                if (idx == cmd.pos)
                begin
                    data_next = cmd.data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/cursor_list_engine.sv -----
`default_nettype none
// an accepted request word yields its registered result word in the next cycle
// throughput: 1 request per cycle while out_ready is high, every cell of the entry chain shifts in the same cycle
// a waiting result does not stall the next request while out_ready is high
// reset clears cursor, count and the result valid flag, capacity returns to 64
// entry contents are not reset and are undefined until written
module cursor_list_engine (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [cle_pkg::CAP_W-1:0]     cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [cle_pkg::REQ_W-1:0]     req_type,
    input  wire logic [cle_pkg::DATA_W-1:0]    value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               ok,
    output logic      [cle_pkg::DATA_W-1:0]    removed_value,
    output logic      [cle_pkg::IDX_W-1:0]     cursor_pos,
    output logic      [cle_pkg::CNT_W-1:0]     item_count,
    output logic                               is_empty,
    output logic                               is_full
);
    import cle_pkg::*;

    logic [CAP_W-1:0]  capacity_reg;
    logic [IDX_W-1:0]  cursor_reg;
    logic [IDX_W-1:0]  cursor_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    logic              ok_reg;
    logic              ok_next;
    logic [DATA_W-1:0] removed_reg;
    logic [DATA_W-1:0] removed_next;
    logic [IDX_W-1:0]  cursor_out_reg;
    logic [CNT_W-1:0]  count_out_reg;
    logic              empty_reg;
    logic              full_reg;

    logic              accept;
    logic              empty_now;
    logic              full_now;
    logic              last_now;
    logic [CMP_W-1:0]  eff_cap;
    cell_cmd_t         cmd;

    logic [DATA_W-1:0] cell_data [MAX_ENTRIES];
    logic [DATA_W-1:0] low_data  [MAX_ENTRIES];
    logic [DATA_W-1:0] high_data [MAX_ENTRIES];

    // entry chain
    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            assign low_data[g] = cell_data[g];
        end
        else
        begin : g_mid_low
            assign low_data[g] = cell_data[g-1];
        end
        if (g == MAX_ENTRIES - 1)
        begin : g_last
            assign high_data[g] = cell_data[g];
        end
        else
        begin : g_mid_high
            assign high_data[g] = cell_data[g+1];
        end

        cle_cell u_cell (
            .clk       (clk),
            .idx       (IDX_W'(g)),
            .cmd       (cmd),
            .low_data  (low_data[g]),
            .high_data (high_data[g]),
            .data      (cell_data[g])
        );
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (capacity_reg == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (CMP_W'(capacity_reg) > CMP_W'(MAX_ENTRIES))
        begin
            eff_cap = CMP_W'(MAX_ENTRIES);
        end
        else
        begin
            eff_cap = CMP_W'(capacity_reg);
        end
    end

    assign empty_now = (count_reg == '0);
    assign full_now  = (CMP_W'(count_reg) >= eff_cap);
    assign last_now  = ((CNT_W'(cursor_reg) + CNT_W'(1)) >= count_reg);

    always_comb
    begin
        cursor_next  = cursor_reg;
        count_next   = count_reg;
        ok_next      = 1'b0;
        removed_next = '0;
        cmd.op       = CELL_HOLD;
        cmd.pos      = cursor_reg;
        cmd.data     = value;
        case (req_type)
            REQ_BEGIN:
            begin
                if (!empty_now)
                begin
                    cursor_next = '0;
                    ok_next     = 1'b1;
                end
            end
            REQ_END:
            begin
                if (!empty_now)
                begin
                    cursor_next = IDX_W'(count_reg - CNT_W'(1));
                    ok_next     = 1'b1;
                end
            end
            REQ_NEXT:
            begin
                if (!empty_now && !last_now)
                begin
                    cursor_next = cursor_reg + IDX_W'(1);
                    ok_next     = 1'b1;
                end
            end
            REQ_PRIOR:
            begin
                if (!empty_now && cursor_reg != '0)
                begin
                    cursor_next = cursor_reg - IDX_W'(1);
                    ok_next     = 1'b1;
                end
            end
            REQ_INS_AFTER:
            begin
                if (!full_now)
                begin
                    cmd.op     = CELL_OPEN;
                    ok_next    = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (empty_now)
                    begin
                        cmd.pos     = '0;
                        cursor_next = '0;
                    end
                    else
                    begin
                        cmd.pos     = cursor_reg + IDX_W'(1);
                        cursor_next = cursor_reg + IDX_W'(1);
                    end
                end
            end
            REQ_INS_BEFORE:
            begin
                if (!full_now)
                begin
                    cmd.op     = CELL_OPEN;
                    ok_next    = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (empty_now)
                    begin
                        cmd.pos     = '0;
                        cursor_next = '0;
                    end
                end
            end
            REQ_REMOVE:
            begin
                if (empty_now)
                begin
                    removed_next = EMPTY_REMOVE_CODE;
                end
                else
                begin
                    cmd.op       = CELL_CLOSE;
                    removed_next = cell_data[cursor_reg];
                    count_next   = count_reg - CNT_W'(1);
                    ok_next      = 1'b1;
                    if (last_now)
                    begin
                        cursor_next = '0;
                    end
                end
            end
            REQ_REPLACE:
            begin
                if (!empty_now)
                begin
                    cmd.op  = CELL_WRITE;
                    ok_next = 1'b1;
                end
            end
            REQ_CLEAR:
            begin
                cursor_next = '0;
                count_next  = '0;
                ok_next     = 1'b1;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
        if (!accept)
        begin
            cmd.op = CELL_HOLD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_RESET;
            cursor_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_data;
            end
            if (accept)
            begin
                cursor_reg    <= cursor_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg         <= ok_next;
            removed_reg    <= removed_next;
            cursor_out_reg <= cursor_next;
            count_out_reg  <= count_next;
            empty_reg      <= (count_next == '0);
            full_reg       <= (CMP_W'(count_next) >= eff_cap);
        end
    end

    assign out_valid     = out_valid_reg;
    assign ok            = ok_reg;
    assign removed_value = removed_reg;
    assign cursor_pos    = cursor_out_reg;
    assign item_count    = count_out_reg;
    assign is_empty      = empty_reg;
    assign is_full       = full_reg;

endmodule
`default_nettype wire
